### rtl/gmsp_pkg.sv
// Shared types and codes for the GRIB2 message section parser.
package gmsp_pkg;

  typedef enum logic [2:0] {
    M_SEARCH  = 3'd0,
    M_LENGTH  = 3'd1,
    M_WALK    = 3'd2,
    M_TRAILER = 3'd3,
    M_HALT    = 3'd4
  } mode_t;

  localparam logic [2:0] EV_START    = 3'd0;
  localparam logic [2:0] EV_SECTION  = 3'd1;
  localparam logic [2:0] EV_END      = 3'd2;
  localparam logic [2:0] EV_ERROR    = 3'd3;
  localparam logic [2:0] EV_NOTFOUND = 3'd4;

  localparam logic [3:0] ER_OVERRUN    = 4'd0;
  localparam logic [3:0] ER_MISALIGNED = 4'd1;
  localparam logic [3:0] ER_NO7777     = 4'd2;
  localparam logic [3:0] ER_BADSECT    = 4'd3;
  localparam logic [3:0] ER_PREDEF_BM  = 4'd4;
  localparam logic [3:0] ER_UNDEF_BM   = 4'd5;
  localparam logic [3:0] ER_SHORTSECT  = 4'd6;
  localparam logic [3:0] ER_SHORTMSG   = 4'd7;
  localparam logic [3:0] ER_TRUNC      = 4'd8;

  localparam logic [31:0] SEARCH_LIMIT_RST = 32'd203200;
  localparam logic [63:0] FIRST_SECTION    = 64'd16;
  localparam logic [63:0] LEN_FIELD_END    = 64'd15;
  localparam logic [63:0] MIN_MSG_LEN      = 64'd20;
  localparam logic [63:0] LEN_FIELD_START  = 64'd7;

  localparam logic [7:0] CH_G = 8'd71;
  localparam logic [7:0] CH_R = 8'd82;
  localparam logic [7:0] CH_I = 8'd73;
  localparam logic [7:0] CH_B = 8'd66;
  localparam logic [7:0] CH_7 = 8'd55;
  localparam logic [7:0] EDITION = 8'd2;
  localparam logic [7:0] BM_REUSE = 8'd254;
  localparam logic [7:0] BM_NONE  = 8'd255;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  error_code;
    logic [63:0] message_position;
    logic [63:0] message_length;
    logic [3:0]  section_number;
    logic [63:0] section_offset;
    logic [31:0] section_length;
    logic [15:0] field_index;
    logic [63:0] bitmap_offset;
    logic [15:0] submessage_count;
  } res_t;

endpackage

### rtl/gmsp_if.sv
// Request and result channel interfaces.
interface gmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface gmsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [3:0]  error_code;
  logic [63:0] message_position;
  logic [63:0] message_length;
  logic [3:0]  section_number;
  logic [63:0] section_offset;
  logic [31:0] section_length;
  logic [15:0] field_index;
  logic [63:0] bitmap_offset;
  logic [15:0] submessage_count;
  modport source (output valid, input ready, output event_res, output error_code,
    output message_position, output message_length, output section_number,
    output section_offset, output section_length, output field_index,
    output bitmap_offset, output submessage_count);
  modport sink (input valid, output ready, input event_res, input error_code,
    input message_position, input message_length, input section_number,
    input section_offset, input section_length, input field_index,
    input bitmap_offset, input submessage_count);
endinterface

### rtl/grib2_message_section_parser.sv
// GRIB2 message section parser top level.
// One byte request per cycle, sustained; the parser classifies each byte
// combinationally and pushes at most one result into a two-entry queue, so input
// ready drops only when that queue is full. A result is queued as its byte is
// accepted. The user must write search_limit through cfg_we/cfg_wdata only
// while the block is idle; the block does not enforce this. It resets to 203200.
module grib2_message_section_parser (
  input  logic        clk,
  input  logic        rst_n,
  gmsp_in_if.sink     in_req,
  gmsp_out_if.source  out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic           room, push;
  gmsp_pkg::res_t push_res;

  gmsp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .room(room), .push(push), .push_res(push_res)
  );

  gmsp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_res(push_res),
    .room(room), .out_res(out_res)
  );

endmodule

### rtl/gmsp_front.sv
// Byte parser: accepts requests, walks the message, emits result records.
module gmsp_front (
  input  logic               clk,
  input  logic               rst_n,
  gmsp_in_if.sink            in_req,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               room,
  output logic               push,
  output gmsp_pkg::res_t     push_res
);

  gmsp_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  hist_r [8];
  logic [7:0]  hist_nxt [8];
  logic [63:0] pos_r, pos_nxt, mstart_r, mstart_nxt, tlen_r, tlen_nxt;
  logic [63:0] off_r, off_nxt, nx_r, nx_nxt, bmo_r, bmo_nxt;
  logic [31:0] acc_r, acc_nxt, scnt_r, scnt_nxt, lim_r, scnt_inc;
  logic [7:0]  cur_r, cur_nxt;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic        bmdef_r, bmdef_nxt;
  logic        acc, fire, trl, fail, fail_sec, adv;
  logic [3:0]  ferr;
  logic [63:0] off1, d, bmo_out;
  logic [7:0]  b;
  gmsp_pkg::res_t res;

  assign acc = in_req.valid && room;
  assign in_req.ready = room;
  assign b = in_req.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= gmsp_pkg::M_SEARCH;
      for (int i = 0; i < 8; i++) hist_r[i] <= '0;
      pos_r   <= '0;
      mstart_r <= '0;
      tlen_r  <= '0;
      off_r   <= '0;
      nx_r    <= gmsp_pkg::FIRST_SECTION;
      acc_r   <= '0;
      cur_r   <= '0;
      fcnt_r  <= '0;
      bmdef_r <= 1'b0;
      bmo_r   <= '0;
      scnt_r  <= '0;
      lim_r   <= gmsp_pkg::SEARCH_LIMIT_RST;
    end else begin
      mode_r  <= mode_nxt;
      for (int i = 0; i < 8; i++) hist_r[i] <= hist_nxt[i];
      pos_r   <= pos_nxt;
      mstart_r <= mstart_nxt;
      tlen_r  <= tlen_nxt;
      off_r   <= off_nxt;
      nx_r    <= nx_nxt;
      acc_r   <= acc_nxt;
      cur_r   <= cur_nxt;
      fcnt_r  <= fcnt_nxt;
      bmdef_r <= bmdef_nxt;
      bmo_r   <= bmo_nxt;
      scnt_r  <= scnt_nxt;
      if (cfg_we) lim_r <= cfg_wdata;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    for (int i = 0; i < 8; i++) hist_nxt[i] = hist_r[i];
    pos_nxt = pos_r;
    mstart_nxt = mstart_r;
    tlen_nxt = tlen_r;
    off_nxt = off_r;
    nx_nxt = nx_r;
    acc_nxt = acc_r;
    cur_nxt = cur_r;
    fcnt_nxt = fcnt_r;
    bmdef_nxt = bmdef_r;
    bmo_nxt = bmo_r;
    scnt_nxt = scnt_r;
    res = '0;
    fire = 1'b0;
    trl = 1'b0;
    fail = 1'b0;
    fail_sec = 1'b0;
    adv = 1'b0;
    ferr = gmsp_pkg::ER_OVERRUN;
    bmo_out = '0;
    off1 = off_r + 64'd1;
    d = off1 - nx_r;
    scnt_inc = (scnt_r == '1) ? scnt_r : scnt_r + 32'd1;
    if (acc) begin
      pos_nxt = pos_r + 64'd1;
      case (mode_r)
        gmsp_pkg::M_SEARCH: begin
          for (int i = 0; i < 7; i++) hist_nxt[i] = hist_r[i+1];
          hist_nxt[7] = b;
          scnt_nxt = scnt_inc;
          if (hist_r[1] == gmsp_pkg::CH_G && hist_r[2] == gmsp_pkg::CH_R &&
              hist_r[3] == gmsp_pkg::CH_I && hist_r[4] == gmsp_pkg::CH_B &&
              b == gmsp_pkg::EDITION) begin
            mstart_nxt = pos_r - 64'd7;
            mode_nxt = gmsp_pkg::M_LENGTH;
            for (int i = 0; i < 8; i++) hist_nxt[i] = '0;
            scnt_nxt = '0;
            off_nxt = gmsp_pkg::LEN_FIELD_START;
            tlen_nxt = '0;
            fcnt_nxt = '0;
            bmdef_nxt = 1'b0;
            bmo_nxt = '0;
            cur_nxt = '0;
            acc_nxt = '0;
            nx_nxt = gmsp_pkg::FIRST_SECTION;
          end else if (scnt_inc >= lim_r) begin
            res.event_res = gmsp_pkg::EV_NOTFOUND;
            fire = 1'b1;
            mode_nxt = gmsp_pkg::M_HALT;
          end
        end
        gmsp_pkg::M_LENGTH: begin
          off_nxt = off1;
          tlen_nxt = {tlen_r[55:0], b};
          if (off1 >= gmsp_pkg::LEN_FIELD_END) begin
            if (tlen_nxt < gmsp_pkg::MIN_MSG_LEN) begin
              fail = 1'b1;
              ferr = gmsp_pkg::ER_SHORTMSG;
            end else begin
              res.event_res = gmsp_pkg::EV_START;
              res.message_position = mstart_r;
              res.message_length = tlen_nxt;
              fire = 1'b1;
              nx_nxt = gmsp_pkg::FIRST_SECTION;
              acc_nxt = '0;
              mode_nxt = gmsp_pkg::M_WALK;
            end
          end
        end
        gmsp_pkg::M_WALK: begin
          off_nxt = off1;
          if (off1 < nx_r) begin
            fire = 1'b0;
          end else if (off1 == nx_r && nx_r == tlen_r - 64'd4) begin
            mode_nxt = gmsp_pkg::M_TRAILER;
            trl = 1'b1;
          end else if (d < 64'd4) begin
            acc_nxt = {acc_r[23:0], b};
          end else if (d == 64'd4) begin
            cur_nxt = b;
            if (b < 8'd1 || b > 8'd7) begin
              fail_sec = 1'b1; ferr = gmsp_pkg::ER_BADSECT;
            end else if (acc_r < 32'd5 || (b == 8'd6 && acc_r < 32'd6)) begin
              fail_sec = 1'b1; ferr = gmsp_pkg::ER_SHORTSECT;
            end else if ({32'd0, acc_r} > tlen_r - nx_r) begin
              fail_sec = 1'b1; ferr = gmsp_pkg::ER_OVERRUN;
            end else if ({32'd0, acc_r} > tlen_r - 64'd4 - nx_r) begin
              fail_sec = 1'b1; ferr = gmsp_pkg::ER_MISALIGNED;
            end else if (b != 8'd6) begin
              adv = 1'b1;
            end
          end else begin
            bmo_out = nx_r;
            if (b >= 8'd1 && b <= 8'd253) begin
              fail_sec = 1'b1; ferr = gmsp_pkg::ER_PREDEF_BM;
            end else if (b == gmsp_pkg::BM_REUSE) begin
              if (!bmdef_r) begin
                fail_sec = 1'b1; ferr = gmsp_pkg::ER_UNDEF_BM;
              end else begin
                bmo_out = bmo_r;
                adv = 1'b1;
              end
            end else if (b == gmsp_pkg::BM_NONE) begin
              adv = 1'b1;
            end else begin
              bmdef_nxt = 1'b1;
              bmo_nxt = nx_r;
              adv = 1'b1;
            end
          end
        end
        gmsp_pkg::M_TRAILER: begin
          off_nxt = off1;
          trl = 1'b1;
        end
        default: begin
          fire = 1'b0;
        end
      endcase
      if (trl) begin
        if (b != gmsp_pkg::CH_7) begin
          fail = 1'b1;
          ferr = gmsp_pkg::ER_NO7777;
        end else if (off1 == tlen_r - 64'd1) begin
          res.event_res = gmsp_pkg::EV_END;
          res.message_position = mstart_r;
          res.message_length = tlen_r;
          res.submessage_count = fcnt_r;
          fire = 1'b1;
          mode_nxt = gmsp_pkg::M_SEARCH;
          for (int i = 0; i < 8; i++) hist_nxt[i] = '0;
          scnt_nxt = '0;
        end
      end
      if (adv || fail_sec) begin
        res.event_res = fail_sec ? gmsp_pkg::EV_ERROR : gmsp_pkg::EV_SECTION;
        res.error_code = fail_sec ? ferr : gmsp_pkg::ER_OVERRUN;
        res.message_position = mstart_r;
        res.message_length = tlen_r;
        res.section_number = cur_nxt[3:0];
        res.section_offset = nx_r;
        res.section_length = acc_r;
        res.field_index = fcnt_r;
        res.bitmap_offset = fail_sec ? 64'd0 : bmo_out;
        fire = 1'b1;
      end
      if (adv) begin
        if (cur_nxt == 8'd7 && fcnt_r != '1) fcnt_nxt = fcnt_r + 16'd1;
        nx_nxt = nx_r + {32'd0, acc_r};
        acc_nxt = '0;
      end
      if (fail) begin
        res = '0;
        res.event_res = gmsp_pkg::EV_ERROR;
        res.error_code = ferr;
        res.message_position = mstart_r;
        res.message_length = tlen_nxt;
        fire = 1'b1;
      end
      if (fail || fail_sec) begin
        mode_nxt = gmsp_pkg::M_SEARCH;
        for (int i = 0; i < 8; i++) hist_nxt[i] = '0;
        scnt_nxt = '0;
      end
      if (in_req.end_of_stream) begin
        if (mode_nxt == gmsp_pkg::M_LENGTH || mode_nxt == gmsp_pkg::M_WALK ||
            mode_nxt == gmsp_pkg::M_TRAILER) begin
          res = '0;
          res.event_res = gmsp_pkg::EV_ERROR;
          res.error_code = gmsp_pkg::ER_TRUNC;
          res.message_position = mstart_nxt;
          res.message_length = tlen_nxt;
          fire = 1'b1;
        end else if (mode_nxt == gmsp_pkg::M_SEARCH && !fire) begin
          res = '0;
          res.event_res = gmsp_pkg::EV_NOTFOUND;
          fire = 1'b1;
        end
        mode_nxt = gmsp_pkg::M_SEARCH;
        for (int i = 0; i < 8; i++) hist_nxt[i] = '0;
        scnt_nxt = '0;
        pos_nxt = '0;
      end
    end
  end

  assign push = acc && fire;
  assign push_res = res;

endmodule

### rtl/gmsp_queue.sv
// Two-entry result queue that drives the result channel.
module gmsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gmsp_pkg::res_t  push_res,
  output logic            room,
  gmsp_out_if.source      out_res
);

  gmsp_pkg::res_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;
  gmsp_pkg::res_t head;

  assign room = (cnt_r != 2'd2);
  assign pop = out_res.valid && out_res.ready;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_res;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_res.valid = (cnt_r != 2'd0);
  assign out_res.event_res = head.event_res;
  assign out_res.error_code = head.error_code;
  assign out_res.message_position = head.message_position;
  assign out_res.message_length = head.message_length;
  assign out_res.section_number = head.section_number;
  assign out_res.section_offset = head.section_offset;
  assign out_res.section_length = head.section_length;
  assign out_res.field_index = head.field_index;
  assign out_res.bitmap_offset = head.bitmap_offset;
  assign out_res.submessage_count = head.submessage_count;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1) else $error("queue drain count");

endmodule

### tb/grib2_message_section_parser_tb.sv
// Testbench for the GRIB2 message section parser: byte streams checked against a built-in model.
`timescale 1ns / 1ps

module grib2_message_section_parser_tb;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  gmsp_in_if in_if ();
  gmsp_out_if out_if ();

  grib2_message_section_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_if),
    .out_res  (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // parser model state
  gmsp_pkg::mode_t p_mode;
  logic [7:0]  p_hist [8];
  logic [63:0] p_spos, p_mstart, p_tlen, p_moff, p_nsec, p_bm_off;
  logic [31:0] p_acc, p_scount, p_limit;
  logic [7:0]  p_cur;
  logic [15:0] p_fcount;
  bit          p_bm_def;

  gmsp_pkg::res_t pending_events [$];
  logic [7:0]  stream_q [$];
  int          items_sent, results_seen, fail_count, streams_sent;
  int          src_idle, snk_idle;

  typedef struct {
    logic [7:0] b;
    bit         eos;
    bit         typed;
    logic [2:0] ev;
    logic [3:0] er;
  } dir_row_t;

  function automatic gmsp_pkg::res_t mk_event(logic [2:0] ev, logic [3:0] er);
    gmsp_pkg::res_t r;
    r = '0;
    r.event_res = ev;
    r.error_code = er;
    r.message_position = p_mstart;
    r.message_length = p_tlen;
    return r;
  endfunction

  function automatic gmsp_pkg::res_t add_section(gmsp_pkg::res_t r, logic [63:0] bmo);
    r.section_number = p_cur[3:0];
    r.section_offset = p_nsec;
    r.section_length = p_acc;
    r.field_index = p_fcount;
    r.bitmap_offset = bmo;
    return r;
  endfunction

  task automatic restart_search();
    p_mode = gmsp_pkg::M_SEARCH;
    foreach (p_hist[i]) p_hist[i] = '0;
    p_scount = '0;
  endtask

  task automatic model_reset();
    restart_search();
    p_spos = '0;
    p_mstart = '0;
    p_tlen = '0;
    p_moff = '0;
    p_nsec = gmsp_pkg::FIRST_SECTION;
    p_acc = '0;
    p_cur = '0;
    p_fcount = '0;
    p_bm_def = 0;
    p_bm_off = '0;
    p_limit = gmsp_pkg::SEARCH_LIMIT_RST;
  endtask

  task automatic raise_error(input logic [3:0] code, input bit with_sec,
                             output bit has, output gmsp_pkg::res_t r);
    r = mk_event(gmsp_pkg::EV_ERROR, code);
    if (with_sec) r = add_section(r, '0);
    restart_search();
    has = 1;
  endtask

  task automatic trailer_step(input logic [7:0] b, input logic [63:0] off,
                              output bit has, output gmsp_pkg::res_t r);
    has = 0;
    r = '0;
    if (b != gmsp_pkg::CH_7) begin
      raise_error(gmsp_pkg::ER_NO7777, 0, has, r);
    end else if (off == p_tlen - 1) begin
      r = mk_event(gmsp_pkg::EV_END, gmsp_pkg::ER_OVERRUN);
      r.submessage_count = p_fcount;
      restart_search();
      has = 1;
    end
  endtask

  task automatic walk_step(input logic [7:0] b, input logic [63:0] off,
                           output bit has, output gmsp_pkg::res_t r);
    logic [63:0] nx, d, len, bmo;
    nx = p_nsec;
    has = 0;
    r = '0;
    if (off < nx) return;
    if (off == nx && nx == p_tlen - 4) begin
      p_mode = gmsp_pkg::M_TRAILER;
      trailer_step(b, off, has, r);
      return;
    end
    d = off - nx;
    if (d < 4) begin
      p_acc = {p_acc[23:0], b};
      return;
    end
    len = {32'd0, p_acc};
    if (d == 4) begin
      p_cur = b;
      if (b < 1 || b > 7) begin
        raise_error(gmsp_pkg::ER_BADSECT, 1, has, r);
        return;
      end
      if (len < 5 || (b == 6 && len < 6)) begin
        raise_error(gmsp_pkg::ER_SHORTSECT, 1, has, r);
        return;
      end
      if (len > p_tlen - nx) begin
        raise_error(gmsp_pkg::ER_OVERRUN, 1, has, r);
        return;
      end
      if (len > p_tlen - 4 - nx) begin
        raise_error(gmsp_pkg::ER_MISALIGNED, 1, has, r);
        return;
      end
      if (b == 6) return;
      r = add_section(mk_event(gmsp_pkg::EV_SECTION, gmsp_pkg::ER_OVERRUN), '0);
    end else begin
      bmo = nx;
      if (b >= 1 && b <= 253) begin
        raise_error(gmsp_pkg::ER_PREDEF_BM, 1, has, r);
        return;
      end
      if (b == gmsp_pkg::BM_REUSE) begin
        if (!p_bm_def) begin
          raise_error(gmsp_pkg::ER_UNDEF_BM, 1, has, r);
          return;
        end
        bmo = p_bm_off;
      end else if (b == 8'd0) begin
        p_bm_def = 1;
        p_bm_off = nx;
      end
      r = add_section(mk_event(gmsp_pkg::EV_SECTION, gmsp_pkg::ER_OVERRUN), bmo);
    end
    if (p_cur == 8'd7 && p_fcount != 16'hFFFF) p_fcount++;
    p_nsec = nx + len;
    p_acc = '0;
    has = 1;
  endtask

  task automatic parse_byte(input logic [7:0] b, input bit eos,
                            output bit has, output gmsp_pkg::res_t r);
    logic [63:0] pos, off;
    pos = p_spos;
    off = p_moff + 1;
    has = 0;
    r = '0;
    p_spos = pos + 1;
    case (p_mode)
      gmsp_pkg::M_SEARCH: begin
        for (int i = 0; i < 7; i++) p_hist[i] = p_hist[i+1];
        p_hist[7] = b;
        if (p_scount != 32'hFFFF_FFFF) p_scount++;
        if (p_hist[0] == gmsp_pkg::CH_G && p_hist[1] == gmsp_pkg::CH_R &&
            p_hist[2] == gmsp_pkg::CH_I && p_hist[3] == gmsp_pkg::CH_B &&
            p_hist[7] == gmsp_pkg::EDITION) begin
          p_mstart = pos - 7;
          p_mode = gmsp_pkg::M_LENGTH;
          foreach (p_hist[i]) p_hist[i] = '0;
          p_scount = '0;
          p_moff = gmsp_pkg::LEN_FIELD_START;
          p_tlen = '0;
          p_fcount = '0;
          p_bm_def = 0;
          p_bm_off = '0;
          p_cur = '0;
          p_acc = '0;
          p_nsec = gmsp_pkg::FIRST_SECTION;
        end else if (p_scount >= p_limit) begin
          r.event_res = gmsp_pkg::EV_NOTFOUND;
          p_mode = gmsp_pkg::M_HALT;
          has = 1;
        end
      end
      gmsp_pkg::M_LENGTH: begin
        p_moff = off;
        p_tlen = {p_tlen[55:0], b};
        if (off >= gmsp_pkg::LEN_FIELD_END) begin
          if (p_tlen < gmsp_pkg::MIN_MSG_LEN) begin
            raise_error(gmsp_pkg::ER_SHORTMSG, 0, has, r);
          end else begin
            r = mk_event(gmsp_pkg::EV_START, gmsp_pkg::ER_OVERRUN);
            p_nsec = gmsp_pkg::FIRST_SECTION;
            p_acc = '0;
            p_mode = gmsp_pkg::M_WALK;
            has = 1;
          end
        end
      end
      gmsp_pkg::M_WALK: begin
        p_moff = off;
        walk_step(b, off, has, r);
      end
      gmsp_pkg::M_TRAILER: begin
        p_moff = off;
        trailer_step(b, off, has, r);
      end
      default: ;
    endcase
    if (eos) begin
      if (p_mode == gmsp_pkg::M_LENGTH || p_mode == gmsp_pkg::M_WALK ||
          p_mode == gmsp_pkg::M_TRAILER) begin
        r = mk_event(gmsp_pkg::EV_ERROR, gmsp_pkg::ER_TRUNC);
        has = 1;
      end else if (p_mode == gmsp_pkg::M_SEARCH && !has) begin
        r = '0;
        r.event_res = gmsp_pkg::EV_NOTFOUND;
        has = 1;
      end
      restart_search();
      p_spos = '0;
    end
  endtask

  // drive one request and predict on acceptance
  task automatic send_byte(input logic [7:0] b, input bit eos, input bit typed = 0,
                           input logic [2:0] ev = '0, input logic [3:0] er = '0);
    bit has;
    gmsp_pkg::res_t r;
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_stream <= eos;
    do @(posedge clk); while (!in_if.ready);
    parse_byte(b, eos, has, r);
    if (typed) begin
      if (!has) r = '0;
      r.event_res = ev;
      r.error_code = er;
      has = 1;
    end
    if (has) pending_events.push_back(r);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    p_limit = v;
  endtask

  task automatic push_section(ref logic [7:0] body[$], input logic [7:0] num);
    int len, pick;
    len = (num == 8'd6) ? $urandom_range(6, 11) : $urandom_range(5, 11);
    for (int i = 3; i >= 0; i--) body.push_back(8'(len >> (8 * i)));
    body.push_back(num);
    for (int i = 5; i < len; i++) begin
      if (num == 8'd6 && i == 5) begin
        pick = $urandom_range(9);
        if (pick < 4) body.push_back(gmsp_pkg::BM_REUSE);
        else if (pick < 7) body.push_back(8'd0);
        else if (pick < 9) body.push_back(gmsp_pkg::BM_NONE);
        else body.push_back(8'($urandom));
      end else begin
        body.push_back(8'($urandom));
      end
    end
  endtask

  task automatic build_message();
    logic [7:0]  body [$];
    logic [63:0] total;
    int          start, fault;
    push_section(body, 8'd1);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(1)) push_section(body, 8'd2);
      for (int s = 3; s <= 7; s++) push_section(body, 8'(s));
    end
    total = 64'(body.size() + 20);
    fault = $urandom_range(11);
    if (fault == 4) total = total - $urandom_range(1, 6);
    if (fault == 5) total = total + $urandom_range(1, 3);
    start = stream_q.size();
    stream_q.push_back(gmsp_pkg::CH_G);
    stream_q.push_back(gmsp_pkg::CH_R);
    stream_q.push_back(gmsp_pkg::CH_I);
    stream_q.push_back(gmsp_pkg::CH_B);
    repeat (3) stream_q.push_back(8'($urandom));
    stream_q.push_back(gmsp_pkg::EDITION);
    for (int i = 7; i >= 0; i--) stream_q.push_back(total[8*i +: 8]);
    foreach (body[i]) stream_q.push_back(body[i]);
    repeat (4) stream_q.push_back(gmsp_pkg::CH_7);
    case (fault)
      0: stream_q[start + $urandom_range(4, stream_q.size() - start - 1)] = 8'($urandom);
      1: for (int i = 8; i < 16; i++) stream_q[start + i] = 8'($urandom);
      2: stream_q[start + 7] = 8'($urandom);
      3: repeat ($urandom_range(1, 12)) void'(stream_q.pop_back());
      default: ;
    endcase
  endtask

  task automatic run_stream(input int long_noise, input int budget);
    int n;
    stream_q.delete();
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, long_noise ? 60 : 6)) stream_q.push_back(8'($urandom));
      build_message();
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 5)) stream_q.push_back(8'($urandom));
    n = (stream_q.size() < budget) ? stream_q.size() : budget;
    for (int i = 0; i < n; i++) send_byte(stream_q[i], i == n - 1);
    streams_sent++;
  endtask

  task automatic run_phase(input int n_items, input int s_idle, input int r_idle,
                           input int long_noise);
    int stop_at;
    src_idle = s_idle;
    snk_idle = r_idle;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) run_stream(long_noise, stop_at - items_sent);
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    gmsp_pkg::res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none actual event %0d", $time,
                 out_if.event_res);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        results_seen++;
        check_field("event_res", want.event_res, out_if.event_res);
        check_field("error_code", want.error_code, out_if.error_code);
        check_field("message_position", want.message_position, out_if.message_position);
        check_field("message_length", want.message_length, out_if.message_length);
        check_field("section_number", want.section_number, out_if.section_number);
        check_field("section_offset", want.section_offset, out_if.section_offset);
        check_field("section_length", want.section_length, out_if.section_length);
        check_field("field_index", want.field_index, out_if.field_index);
        check_field("bitmap_offset", want.bitmap_offset, out_if.bitmap_offset);
        check_field("submessage_count", want.submessage_count, out_if.submessage_count);
      end
    end
  end

  always @(negedge clk) out_if.ready <= rst_n && ($urandom_range(99) >= snk_idle);

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_if.valid = 0;
    in_if.data_byte = '0;
    in_if.end_of_stream = 0;
    src_idle = 0;
    snk_idle = 0;
    model_reset();

    // lone end of stream, short message, missing request after magic, truncation
    dir_rows.push_back('{8'h00, 1, 1, gmsp_pkg::EV_NOTFOUND, gmsp_pkg::ER_OVERRUN});
    dir_rows.push_back('{gmsp_pkg::CH_G, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::CH_R, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::CH_I, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::CH_B, 0, 0, 0, 0});
    dir_rows.push_back('{8'hFF, 0, 0, 0, 0});
    dir_rows.push_back('{8'h00, 0, 0, 0, 0});
    dir_rows.push_back('{8'hAA, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::EDITION, 0, 0, 0, 0});
    repeat (7) dir_rows.push_back('{8'h00, 0, 0, 0, 0});
    dir_rows.push_back('{8'd19, 0, 1, gmsp_pkg::EV_ERROR, gmsp_pkg::ER_SHORTMSG});
    dir_rows.push_back('{8'hFF, 1, 1, gmsp_pkg::EV_NOTFOUND, gmsp_pkg::ER_OVERRUN});
    dir_rows.push_back('{gmsp_pkg::CH_G, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::CH_R, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::CH_I, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::CH_B, 0, 0, 0, 0});
    repeat (3) dir_rows.push_back('{8'h55, 0, 0, 0, 0});
    dir_rows.push_back('{gmsp_pkg::EDITION, 0, 0, 0, 0});
    dir_rows.push_back('{8'hFF, 1, 1, gmsp_pkg::EV_ERROR, gmsp_pkg::ER_TRUNC});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].ev,
                dir_rows[i].er);

    run_phase(560, 27, 85, 0);
    write_limit(32'd0);
    run_phase(60, 0, 0, 0);
    write_limit(32'd40);
    run_phase(560, 85, 27, 1);
    write_limit(32'hFFFF_FFFF);
    run_phase(540, 0, 0, 1);
    drain_results();

    $display("covered %0d byte requests in %0d streams, %0d results checked", items_sent,
             streams_sent, results_seen);
    $display("search limits default, 0, 40 and max; %0d mismatches", fail_count);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
